[design/particle_sensor_frame_parser_unit_macros.svh]
// Assertion macros for the particulate sensor frame parser.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef PARTICLE_SENSOR_FRAME_PARSER_UNIT_MACROS_SVH
`define PARTICLE_SENSOR_FRAME_PARSER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/psfp_pkg.sv]
// Shared types, constants and helper functions of the particulate sensor frame parser.
// No dependencies; used by the parser, emitter and top level.
package psfp_pkg;

  localparam logic [7:0] START_A = 8'h42;
  localparam logic [7:0] START_B = 8'h4D;

  localparam logic [15:0] LEN_SHORT = 16'(2 * 9 + 2);
  localparam logic [15:0] LEN_LONG  = 16'(2 * 13 + 2);

  // Frame positions: payload starts after start pair and length; checksum follows payload.
  localparam logic [4:0] PAYLOAD_POS    = 5'd4;
  localparam logic [4:0] CKS_POS_SHORT  = 5'(2 * 9 + 2 + 2);
  localparam logic [4:0] CKS_POS_LONG   = 5'(2 * 13 + 2 + 2);

  localparam int PAIR_IDX_W = 4;
  localparam int SEQ_W      = 4;
  localparam int PROD_W     = 33;

  // Result word codes that differ from a plain payload pair.
  localparam logic [SEQ_W-1:0] WORD_HCHO  = 4'd12;
  localparam logic [SEQ_W-1:0] WORD_TEMP  = 4'd13;
  localparam logic [SEQ_W-1:0] WORD_HUMID = 4'd14;

  // Payload pairs that feed the derived words.
  localparam logic [PAIR_IDX_W-1:0] PAIR_TEMP  = 4'd10;
  localparam logic [PAIR_IDX_W-1:0] PAIR_HUMID = 4'd11;
  localparam logic [PAIR_IDX_W-1:0] PAIR_HCHO  = 4'd12;
  // Pairs from here up are read again late in a run.
  localparam logic [PAIR_IDX_W-1:0] REREAD_FIRST = PAIR_TEMP;

  // Truncating division by reciprocal multiply, exact for 16-bit operands.
  localparam logic [16:0] MUL_PLAIN    = 17'd1;
  localparam logic [16:0] DIV10_MUL    = 17'd52429;
  localparam int          DIV10_SHIFT  = 19;
  localparam logic [16:0] DIV1000_MUL  = 17'd67109;
  localparam int          DIV1000_SHIFT = 26;

  typedef struct packed {
    logic                  en;
    logic                  odd;
    logic [PAIR_IDX_W-1:0] pair;
    logic [7:0]            data;
  } psfp_wr_t;

  typedef struct packed {
    logic             active;
    logic [SEQ_W-1:0] seq;
  } psfp_stat_t;

  function automatic logic [PAIR_IDX_W-1:0] seq_pair(input logic [SEQ_W-1:0] seq);
    logic [PAIR_IDX_W-1:0] p;
    case (seq)
      WORD_HCHO:  p = PAIR_HCHO;
      WORD_TEMP:  p = PAIR_TEMP;
      WORD_HUMID: p = PAIR_HUMID;
      default:    p = PAIR_IDX_W'(seq);
    endcase
    return p;
  endfunction

  function automatic logic [16:0] seq_mul(input logic [SEQ_W-1:0] seq);
    logic [16:0] m;
    case (seq)
      WORD_HCHO:  m = DIV1000_MUL;
      WORD_TEMP:  m = DIV10_MUL;
      WORD_HUMID: m = DIV10_MUL;
      default:    m = MUL_PLAIN;
    endcase
    return m;
  endfunction

endpackage

[design/psfp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/psfp_parser.sv]
// Byte-level frame tracker: start pair, length, payload writes and checksum check.
// Depends on psfp_pkg; drives the payload store write port and the run start pulse.
module psfp_parser #(
  parameter int PAYLOAD_BYTES = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  input  logic [7:0]           rx_byte,
  output logic                 rx_ready,
  input  psfp_pkg::psfp_stat_t stat,
  output psfp_pkg::psfp_wr_t   wr,
  output logic                 start
);

  logic [4:0]  pos;
  logic        len_long;
  logic [7:0]  len_hi;
  logic [15:0] running_sum;
  logic [7:0]  rsum_hi;

  logic        accept;
  logic [4:0]  cks_hi;
  logic [4:0]  cks_lo;
  logic [4:0]  idx;
  logic        in_body;
  logic        is_cks_hi;
  logic        is_final;
  logic        is_payload;
  logic        storable;
  logic        wr_blocked;
  logic [15:0] flen;
  logic [15:0] sum_add;

  always_comb begin
    cks_hi     = len_long ? psfp_pkg::CKS_POS_LONG : psfp_pkg::CKS_POS_SHORT;
    cks_lo     = cks_hi + 5'd1;
    idx        = pos - psfp_pkg::PAYLOAD_POS;
    in_body    = pos >= psfp_pkg::PAYLOAD_POS;
    is_cks_hi  = in_body && (pos == cks_hi);
    is_final   = in_body && (pos == cks_lo);
    is_payload = in_body && !is_cks_hi && !is_final;
    storable   = {1'b0, idx} < 6'(PAYLOAD_BYTES);
    // A new payload byte may not overwrite a pair the running burst has yet to read.
    wr_blocked = is_payload && storable &&
                 ((idx[4:1] >= stat.seq) || (idx[4:1] >= psfp_pkg::REREAD_FIRST));
    rx_ready   = !(stat.active && (wr_blocked || is_final));
    accept     = rx_valid && rx_ready;
    flen       = {len_hi, rx_byte};
    sum_add    = running_sum + {8'd0, rx_byte};

    wr.en      = accept && is_payload && storable;
    wr.odd     = idx[0];
    wr.pair    = idx[4:1];
    wr.data    = rx_byte;
    start      = accept && is_final && (running_sum == {rsum_hi, rx_byte});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      len_long    <= 1'b0;
      len_hi      <= '0;
      running_sum <= '0;
      rsum_hi     <= '0;
    end else if (accept) begin
      case (pos)
        5'd0: begin
          if (rx_byte == psfp_pkg::START_A) begin
            running_sum <= {8'd0, rx_byte};
            pos         <= 5'd1;
          end
        end
        5'd1: begin
          if (rx_byte == psfp_pkg::START_B) begin
            running_sum <= sum_add;
            pos         <= 5'd2;
          end else begin
            pos <= 5'd0;
          end
        end
        5'd2: begin
          running_sum <= sum_add;
          len_hi      <= rx_byte;
          pos         <= 5'd3;
        end
        5'd3: begin
          if (flen == psfp_pkg::LEN_SHORT || flen == psfp_pkg::LEN_LONG) begin
            len_long    <= (flen == psfp_pkg::LEN_LONG);
            running_sum <= sum_add;
            pos         <= 5'd4;
          end else begin
            pos <= 5'd0;
          end
        end
        default: begin
          if (is_cks_hi) begin
            rsum_hi <= rx_byte;
            pos     <= pos + 5'd1;
          end else if (is_final) begin
            pos <= 5'd0;
          end else begin
            running_sum <= sum_add;
            pos         <= pos + 5'd1;
          end
        end
      endcase
    end
  end

endmodule

[design/psfp_emitter.sv]
// Payload store (even and odd byte RAMs with reset-valid bits) and the result word pipeline.
// Depends on psfp_pkg, psfp_ram and the assertion macro header.
`include "particle_sensor_frame_parser_unit_macros.svh"

module psfp_emitter #(
  parameter int PAYLOAD_BYTES = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  psfp_pkg::psfp_wr_t   wr,
  input  logic                 start,
  output psfp_pkg::psfp_stat_t stat,
  output logic                 word_valid,
  input  logic                 word_ready,
  output logic [3:0]           word_select,
  output logic [15:0]          word_value,
  output logic                 last_word
);

  localparam int PAIR_DEPTH = (PAYLOAD_BYTES + 1) / 2;
  localparam int AW = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

  logic                       active;
  logic [psfp_pkg::SEQ_W-1:0] seq;
  logic [PAIR_DEPTH-1:0]      vld_even;
  logic [PAIR_DEPTH-1:0]      vld_odd;

  logic                       adv;
  logic                       issue;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic                       we_even;
  logic                       we_odd;
  logic [7:0]                 q_even;
  logic [7:0]                 q_odd;
  logic [15:0]                pair_val;

  logic                       s1_v;
  logic [psfp_pkg::SEQ_W-1:0] s1_sel;
  logic                       s1_ve;
  logic                       s1_vo;
  logic                       s2_v;
  logic [psfp_pkg::SEQ_W-1:0] s2_sel;
  logic [psfp_pkg::PROD_W-1:0] s2_prod;

  assign stat.active = active;
  assign stat.seq    = seq;

  assign adv      = !word_valid || word_ready;
  assign issue    = active && adv;
  assign waddr    = AW'(wr.pair);
  assign raddr    = AW'(psfp_pkg::seq_pair(seq));
  assign we_even  = wr.en && !wr.odd;
  assign we_odd   = wr.en && wr.odd;
  assign pair_val = {s1_ve ? q_even : 8'd0, s1_vo ? q_odd : 8'd0};

  psfp_ram #(.WIDTH(8), .DEPTH(PAIR_DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (wr.data),
    .re    (issue),
    .raddr (raddr),
    .rdata (q_even)
  );

  psfp_ram #(.WIDTH(8), .DEPTH(PAIR_DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (wr.data),
    .re    (issue),
    .raddr (raddr),
    .rdata (q_odd)
  );

  // Run sequencer and valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      seq      <= '0;
      vld_even <= '0;
      vld_odd  <= '0;
    end else begin
      if (we_even) begin
        vld_even[waddr] <= 1'b1;
      end
      if (we_odd) begin
        vld_odd[waddr] <= 1'b1;
      end
      if (start) begin
        active <= 1'b1;
        seq    <= '0;
      end else if (issue) begin
        seq <= seq + psfp_pkg::SEQ_W'(1);
        if (seq == psfp_pkg::WORD_HUMID) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      word_valid <= 1'b0;
    end else if (adv) begin
      s1_v       <= issue;
      s2_v       <= s1_v;
      word_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sel <= seq;
      s1_ve  <= vld_even[raddr];
      s1_vo  <= vld_odd[raddr];
    end
    if (adv) begin
      s2_sel      <= s1_sel;
      s2_prod     <= {17'd0, pair_val} * {16'd0, psfp_pkg::seq_mul(s1_sel)};
      word_select <= s2_sel;
      last_word   <= (s2_sel == psfp_pkg::WORD_HUMID);
      case (s2_sel)
        psfp_pkg::WORD_HCHO:  word_value <= 16'(s2_prod >> psfp_pkg::DIV1000_SHIFT);
        psfp_pkg::WORD_TEMP:  word_value <= 16'(s2_prod >> psfp_pkg::DIV10_SHIFT);
        psfp_pkg::WORD_HUMID: word_value <= 16'(s2_prod >> psfp_pkg::DIV10_SHIFT);
        default:              word_value <= s2_prod[15:0];
      endcase
    end
  end

  `PSFP_ASSERT_NOW(a_start_when_idle, start, !active, "run started while a run is active")
  `PSFP_ASSERT_NEXT(a_run_ends, issue && (seq == psfp_pkg::WORD_HUMID), !active, "run did not end")
  `PSFP_ASSERT_NOW(a_seq_bound, active, seq <= psfp_pkg::WORD_HUMID, "read sequence overran")
  `PSFP_ASSERT_NOW(a_last_tag, word_valid && last_word, word_select == psfp_pkg::WORD_HUMID, "last flag on wrong word")

endmodule

[design/particle_sensor_frame_parser_unit.sv]
// Top level of the particulate sensor serial frame parser.
// Depends on psfp_pkg, psfp_parser, psfp_emitter (which holds the psfp_ram payload store).
//
// Usage: serial bytes enter on the rx channel (rx_valid, rx_ready, rx_byte), one word per
// accepted handshake. The parser hunts for the start pair 0x42 0x4D, checks the big-endian
// length (20 or 28), stores the payload and compares the 16-bit running sum with the frame
// checksum. On a match, 15 result words leave on the word channel (word_valid, word_ready,
// word_select, word_value, last_word), codes 0 to 14 in order, last_word set on code 14.
// A bad header or checksum produces no words.
// Once the final checksum byte is accepted a run starts; each word passes the RAM read,
// product and output registers; words move one per cycle while word_ready stays high.
// Throughput: one byte per cycle. The payload store is a pair of byte-wide RAMs with one
// read port, read once per result word; a payload byte waits while its pair is still
// due to be read by the burst in progress, and the final checksum byte of a following
// frame waits until the burst has issued all its reads.
// Reset (rst, synchronous) returns the parser to hunting and marks every payload entry
// as zero through per-entry valid bits; no clearing pass is needed.
// When the receiver stalls, the result pipeline holds in place; bytes keep being accepted
// until a payload write would reach a pair not yet read.
module particle_sensor_frame_parser_unit #(
  parameter int PAYLOAD_BYTES = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [3:0]  word_select,
  output logic [15:0] word_value,
  output logic        last_word
);

  // Write port of the payload store, run status and run start travel between the halves.
  psfp_pkg::psfp_wr_t   wr;
  psfp_pkg::psfp_stat_t stat;
  logic                 start;

  psfp_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .rx_ready (rx_ready),
    .stat     (stat),
    .wr       (wr),
    .start    (start)
  );

  psfp_emitter #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emitter (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .start       (start),
    .stat        (stat),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word_select (word_select),
    .word_value  (word_value),
    .last_word   (last_word)
  );

endmodule

[sim/particle_sensor_frame_parser_unit_tb.sv]
// Self-checking testbench for the particulate sensor frame parser top level.
// Depends on psfp_pkg and particle_sensor_frame_parser_unit; drives byte frames and
// checks every decoded result word against a cycle-free model of the frame decoder.
module particle_sensor_frame_parser_unit_tb;

  // Depth of the payload store and the decoded word layout.
  localparam int STORE_DEPTH  = 26;
  localparam int NUM_WORDS    = 15;
  localparam int HCHO_SCALE   = 1000;
  localparam int CLIMATE_SCALE = 10;

  // Header positions within a frame.
  localparam logic [4:0] POS_START_A = 5'd0;
  localparam logic [4:0] POS_START_B = 5'd1;
  localparam logic [4:0] POS_LEN_HI  = 5'd2;
  localparam logic [4:0] POS_LEN_LO  = 5'd3;

  // Run limits: cycles without any accepted word, and the settle time at the end.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES  = 24;
  localparam int MAX_PRINTED  = 40;

  // Flow-control settings of the four random phases, in percent.
  localparam int SRC_IDLE_PCT[4]   = '{0, 53, 0, 11};
  localparam int SINK_STALL_PCT[4] = '{0, 0, 53, 11};

  typedef enum int {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_LEN, FRM_BAD_START, FRM_NOISE} frame_kind_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct {
    logic [3:0]  sel;
    logic [15:0] value;
    logic        last;
  } sensor_word_t;

  // Tracks the parser state as bytes are accepted and holds the words each good
  // frame must produce, oldest first.
  class sensor_word_tracker;
    logic [4:0]   position;
    logic [15:0]  frame_len;
    logic [15:0]  run_sum;
    logic [15:0]  rx_sum;
    logic [7:0]   store[STORE_DEPTH];
    sensor_word_t pending_words[$];
    int           errors;
    int           words_checked;
    int           frames_decoded;

    function new();
      position = '0;
      frame_len = '0;
      run_sum = '0;
      rx_sum = '0;
      foreach (store[i]) store[i] = 8'h00;
      errors = 0;
      words_checked = 0;
      frames_decoded = 0;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function logic [15:0] pair_word(input logic [3:0] p);
      return {store[2 * p], store[2 * p + 1]};
    endfunction

    function void note_byte(input logic [7:0] b);
      sensor_word_t w;
      logic [3:0]   sel;
      int           idx;
      case (position)
        POS_START_A: begin
          if (b == psfp_pkg::START_A) begin
            run_sum = 16'(b);
            position = POS_START_B;
          end
        end
        POS_START_B: begin
          if (b != psfp_pkg::START_B) begin
            position = POS_START_A;
          end else begin
            run_sum = run_sum + 16'(b);
            position = POS_LEN_HI;
          end
        end
        POS_LEN_HI: begin
          run_sum = run_sum + 16'(b);
          frame_len = {b, 8'h00};
          position = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          frame_len = {frame_len[15:8], b};
          if (frame_len != psfp_pkg::LEN_SHORT && frame_len != psfp_pkg::LEN_LONG) begin
            position = POS_START_A;
          end else begin
            run_sum = run_sum + 16'(b);
            position = position + 5'd1;
          end
        end
        default: begin
          if (int'(position) == int'(frame_len) + 2) begin
            rx_sum = {b, 8'h00};
            position = position + 5'd1;
          end else if (int'(position) == int'(frame_len) + 3) begin
            rx_sum = {rx_sum[15:8], b};
            position = POS_START_A;
            if (rx_sum == run_sum) begin
              frames_decoded++;
              for (int k = 0; k < NUM_WORDS; k++) begin
                sel = 4'(k);
                case (sel)
                  psfp_pkg::WORD_HCHO:
                    w.value = 16'(pair_word(psfp_pkg::PAIR_HCHO) / HCHO_SCALE);
                  psfp_pkg::WORD_TEMP:
                    w.value = 16'(pair_word(psfp_pkg::PAIR_TEMP) / CLIMATE_SCALE);
                  psfp_pkg::WORD_HUMID:
                    w.value = 16'(pair_word(psfp_pkg::PAIR_HUMID) / CLIMATE_SCALE);
                  default:
                    w.value = pair_word(sel);
                endcase
                w.sel = sel;
                w.last = (k == NUM_WORDS - 1);
                pending_words.push_back(w);
              end
            end
          end else begin
            idx = int'(position) - 4;
            run_sum = run_sum + 16'(b);
            if (idx < STORE_DEPTH) store[idx] = b;
            position = position + 5'd1;
          end
        end
      endcase
    endfunction

    task check_word(input logic [3:0] sel, input logic [15:0] value, input logic last);
      sensor_word_t w;
      words_checked++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word select=%0d value=%0d last=%0b", sel, value, last));
      end else begin
        w = pending_words.pop_front();
        if (sel !== w.sel)
          report($sformatf("word_select %0d, expected %0d", sel, w.sel));
        if (value !== w.value)
          report($sformatf("word_value %0d on select %0d, expected %0d", value, w.sel, w.value));
        if (last !== w.last)
          report($sformatf("last_word %0b on select %0d, expected %0b", last, w.sel, w.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        word_valid;
  logic        word_ready;
  logic [3:0]  word_select;
  logic [15:0] word_value;
  logic        last_word;

  sensor_word_tracker tracker;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;
  int phase_bytes = 0;
  int bytes_sent = 0;

  particle_sensor_frame_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_byte     (rx_byte),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word_select (word_select),
    .word_value  (word_value),
    .last_word   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // All handshakes are observed here, at the rising edge, before the block's own
  // registers update. Input words are fed to the tracker first, so the order of
  // events within one edge never matters.
  always @(posedge clk) begin
    if (!rst && rx_valid && rx_ready) tracker.note_byte(rx_byte);
    if (!rst && word_valid && word_ready) tracker.check_word(word_select, word_value, last_word);
    if (rst || (rx_valid && rx_ready) || (word_valid && word_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // The receiver decides at each falling edge whether it takes a word in the
  // next cycle.
  initial begin
    word_ready = 1'b0;
    forever begin
      @(negedge clk);
      word_ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // A run that stops moving words for too long is a hang.
  initial begin
    @(negedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
    $display("** particle_sensor_frame_parser_unit: FAILED **");
    $finish;
  end

  // Offers one byte as an input word, after an optional random gap, and returns at
  // the falling edge after it was taken. Valid stays high from one word to the next
  // unless the following call idles first.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_valid = 1'b0;
      rx_byte = 8'($urandom_range(0, 255));
      @(negedge clk);
    end
    rx_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Builds one byte sequence of the given kind and sends it. Good frames and
  // frames with a corrupted checksum carry a full header and payload; the other
  // kinds stop after the start pair or header, or are bare random bytes.
  task automatic send_frame(input frame_kind_t kind, input bit short_len, input fill_t fill);
    logic [7:0]  seq_q[$];
    logic [15:0] len;
    logic [15:0] sum;
    logic [7:0]  b;
    int          n;
    len = short_len ? psfp_pkg::LEN_SHORT : psfp_pkg::LEN_LONG;
    sum = '0;
    case (kind)
      FRM_NOISE: begin
        n = $urandom_range(1, 4);
        repeat (n) seq_q.push_back(8'($urandom_range(0, 255)));
      end
      FRM_BAD_START: begin
        // Half of these repeat the first start byte, which must not restart the hunt.
        b = $urandom_range(0, 1) ? psfp_pkg::START_A : 8'($urandom_range(0, 255));
        if (b == psfp_pkg::START_B) b = ~b;
        seq_q.push_back(psfp_pkg::START_A);
        seq_q.push_back(b);
        n = $urandom_range(0, 6);
        repeat (n) seq_q.push_back(8'($urandom_range(0, 255)));
      end
      FRM_BAD_LEN: begin
        len = 16'($urandom_range(0, 65535));
        if (len == psfp_pkg::LEN_SHORT || len == psfp_pkg::LEN_LONG) len = len ^ 16'h0001;
        seq_q = '{psfp_pkg::START_A, psfp_pkg::START_B, len[15:8], len[7:0]};
        n = $urandom_range(0, 6);
        repeat (n) seq_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        seq_q = '{psfp_pkg::START_A, psfp_pkg::START_B, len[15:8], len[7:0]};
        for (int i = 0; i < int'(len) - 2; i++) begin
          case (fill)
            FILL_ONES:  seq_q.push_back(8'hFF);
            FILL_ZEROS: seq_q.push_back(8'h00);
            default:    seq_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        foreach (seq_q[i]) sum = sum + 16'(seq_q[i]);
        if (kind == FRM_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        seq_q.push_back(sum[15:8]);
        seq_q.push_back(sum[7:0]);
      end
    endcase
    foreach (seq_q[i]) send_byte(seq_q[i]);
    if (kind != FRM_NOISE) phase_bytes += seq_q.size();
  endtask

  initial begin
    int          r;
    frame_kind_t kind;
    fill_t       fill;
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = 8'h00;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with no idling on either side; its frames count toward the
    // share of the first flow-control phase.
    // Bytes while hunting, including a lone second start byte, are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(psfp_pkg::START_B);
    // A repeated first start byte is not a new start: the following second
    // start byte is dropped too.
    send_byte(psfp_pkg::START_A);
    send_byte(psfp_pkg::START_A);
    send_byte(psfp_pkg::START_B);
    // A bad length header sends the parser back to hunting.
    send_frame(FRM_BAD_LEN, 1'b0, FILL_RANDOM);
    // Extreme payloads: all ones, then a short frame of zeros that leaves the
    // ones in the upper pairs for the derived words to read.
    send_frame(FRM_GOOD, 1'b0, FILL_ONES);
    send_frame(FRM_GOOD, 1'b1, FILL_ZEROS);

    // Random part: mostly well-formed frames with random content, the rest broken
    // sequences and noise, in four flow-control phases.
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct = SRC_IDLE_PCT[phase];
      sink_stall_pct = SINK_STALL_PCT[phase];
      if (phase != 0) phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 60) kind = FRM_GOOD;
        else if (r < 80) kind = FRM_BAD_SUM;
        else if (r < 87) kind = FRM_BAD_LEN;
        else if (r < 94) kind = FRM_BAD_START;
        else kind = FRM_NOISE;
        r = $urandom_range(0, 9);
        fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
        send_frame(kind, ($urandom_range(0, 3) == 0), fill);
      end
    end
    rx_valid = 1'b0;

    // Let the last bursts drain, then watch a little longer for stray words.
    while (tracker.pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.pending_words.size() != 0)
      tracker.report($sformatf("%0d words never arrived", tracker.pending_words.size()));

    $display("Sent %0d bytes over directed frames and four flow-control phases.", bytes_sent);
    $display("Decoded %0d good frames, checked %0d result words, %0d mismatches.",
             tracker.frames_decoded, tracker.words_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("** particle_sensor_frame_parser_unit: PASSED **");
    end else begin
      $display("** particle_sensor_frame_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/psfp_pkg.sv
design/psfp_ram.sv
design/psfp_parser.sv
design/psfp_emitter.sv
design/particle_sensor_frame_parser_unit.sv
sim/particle_sensor_frame_parser_unit_tb.sv
